// ===== sv/swfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sync word frame deframer package
// Shared constants, the phase encoding and the control bundle that passes
// from the frame sequencer to the datapath.
// ----------------------------------------------------------------------------
package swfd_pkg;

  // Byte and word widths of the stream and of the result.
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  // Number of word slots on the result and number of words in one frame.
  localparam int unsigned WordSlots  = 8;
  localparam int unsigned FrameWords = 8;
  localparam int unsigned SlotW      = $clog2(WordSlots);
  localparam int unsigned CntW       = (FrameWords > 1) ? $clog2(FrameWords) : 1;

  // Value of the sync byte register after reset.
  localparam logic [ByteW-1:0] SyncReset = 8'hFF;

  // Receive phase of the deframer.
  typedef enum logic [2:0] {
    PhHunt1   = 3'd0,
    PhHunt2   = 3'd1,
    PhFirstHi = 3'd2,
    PhLo      = 3'd3,
    PhHi      = 3'd4
  } phase_e;

  // Strobes and slot index from the sequencer to the word storage.
  typedef struct packed {
    logic             hi_we;
    logic             lo_we;
    logic [SlotW-1:0] slot;
    logic             last;
    logic             done;
  } ctrl_t;

endpackage

// ===== sv/sync_word_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Sync word frame deframer
// Hunts for a frame of two or more sync bytes followed by 16-bit words sent
// high byte first, and delivers the whole frame as one transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the rx channel (rx_valid_i / rx_ready_o / rx_byte_i), one
//   transaction per byte. A completed frame leaves on the frame channel
//   (frame_valid_o / frame_ready_i) with all eight words side by side; words
//   past the frame length read as zero.
//   The sync byte value is written through cfg_we_i / cfg_data_i while the
//   block is idle; it takes effect on the next byte.
//   Throughput is one byte per cycle while rx_ready_o is high. The frame
//   is registered on the clock edge that accepts its last low byte.
//   The result register decouples the two sides: bytes keep flowing while a
//   frame waits. Only the byte that would close the next frame is held off
//   while the previous frame is still waiting and frame_ready_i is low.
//   Reset clears the phase to hunting, the word count, the result valid and
//   sets the sync byte to 0xFF. The word storage needs no reset since every
//   slot is written before it is delivered.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [swfd_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                         rx_valid_i,
  output logic                         rx_ready_o,
  input  logic [swfd_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         frame_valid_o,
  input  logic                         frame_ready_i,
  output logic [swfd_pkg::WordW-1:0]   word0_o,
  output logic [swfd_pkg::WordW-1:0]   word1_o,
  output logic [swfd_pkg::WordW-1:0]   word2_o,
  output logic [swfd_pkg::WordW-1:0]   word3_o,
  output logic [swfd_pkg::WordW-1:0]   word4_o,
  output logic [swfd_pkg::WordW-1:0]   word5_o,
  output logic [swfd_pkg::WordW-1:0]   word6_o,
  output logic [swfd_pkg::WordW-1:0]   word7_o
);
  import swfd_pkg::*;

  logic [ByteW-1:0] sync_q;
  logic             accept;
  logic             is_sync;
  ctrl_t            ctrl;

  logic [ByteW-1:0] hi_q [FrameWords];
  logic [ByteW-1:0] lo_q [FrameWords];
  logic [WordW-1:0] frame_d [WordSlots];
  logic [WordW-1:0] words_q [WordSlots];
  logic             valid_q, valid_d;

  // Sync byte register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
    end else if (cfg_we_i) begin
      sync_q <= cfg_data_i;
    end
  end

  // Hold off only the closing byte while a frame still waits downstream.
  assign rx_ready_o = !(ctrl.last && valid_q && !frame_ready_i);
  assign accept     = rx_valid_i && rx_ready_o;
  assign is_sync    = (rx_byte_i == sync_q);

  swfd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .is_sync_i (is_sync),
    .ctrl_o    (ctrl)
  );

  // Word storage: high and low bytes written at the current slot.
  always_ff @(posedge clk_i) begin
    if (ctrl.hi_we) begin
      hi_q[ctrl.slot[CntW-1:0]] <= rx_byte_i;
    end
    if (ctrl.lo_we) begin
      lo_q[ctrl.slot[CntW-1:0]] <= rx_byte_i;
    end
  end

  // Assemble the result; the final low byte is merged from the input.
  for (genvar k = 0; k < WordSlots; k++) begin : g_word
    if (k < FrameWords) begin : g_used
      assign frame_d[k] = (ctrl.slot == SlotW'(k)) ? {hi_q[k], rx_byte_i}
                                                   : {hi_q[k], lo_q[k]};
    end else begin : g_unused
      assign frame_d[k] = '0;
    end
  end

  // Result valid flag.
  always_comb begin
    valid_d = valid_q;
    if (ctrl.done) begin
      valid_d = 1'b1;
    end else if (frame_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      words_q <= frame_d;
    end
  end

  assign frame_valid_o = valid_q;
  assign word0_o       = words_q[0];
  assign word1_o       = words_q[1];
  assign word2_o       = words_q[2];
  assign word3_o       = words_q[3];
  assign word4_o       = words_q[4];
  assign word5_o       = words_q[5];
  assign word6_o       = words_q[6];
  assign word7_o       = words_q[7];

endmodule

// ===== sv/swfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sync word frame sequencer
// Tracks the receive phase and the word count, and tells the datapath which
// byte of which word the current byte is.
// ----------------------------------------------------------------------------
module swfd_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       is_sync_i,
  output swfd_pkg::ctrl_t            ctrl_o
);
  import swfd_pkg::*;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic            last_word;

  // The low byte of the final word closes the frame.
  assign last_word = (count_q == CntW'(FrameWords - 1));

  // Phase and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt1;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // Next phase and next word count for an accepted byte.
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (accept_i) begin
      unique case (phase_q)
        PhHunt1: begin
          if (is_sync_i) phase_d = PhHunt2;
        end
        PhHunt2: begin
          phase_d = is_sync_i ? PhFirstHi : PhHunt1;
        end
        PhFirstHi: begin
          count_d = '0;
          if (!is_sync_i) phase_d = PhLo;
        end
        PhLo: begin
          if (last_word) begin
            phase_d = PhHunt1;
          end else begin
            count_d = count_q + CntW'(1);
            phase_d = PhHi;
          end
        end
        PhHi: begin
          phase_d = is_sync_i ? PhHunt2 : PhLo;
        end
        default: begin
          phase_d = PhHunt1;
        end
      endcase
    end
  end

  // Strobes for the word storage and the result register.
  always_comb begin
    ctrl_o.hi_we = accept_i && !is_sync_i && ((phase_q == PhFirstHi) || (phase_q == PhHi));
    ctrl_o.lo_we = accept_i && (phase_q == PhLo);
    ctrl_o.slot  = (phase_q == PhFirstHi) ? '0 : SlotW'(count_q);
    ctrl_o.last  = (phase_q == PhLo) && last_word;
    ctrl_o.done  = ctrl_o.lo_we && last_word;
  end

endmodule

// ===== tb/sync_word_frame_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sync word frame deframer testbench
// Streams bytes into the deframer and tracks its frame hunting in a local
// model. Every delivered frame is checked word by word against the model. The
// sync byte is reprogrammed between phases. Both channels stall at random, and
// the frame side also holds off for a long stretch to back up the byte input.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_tb;
  import swfd_pkg::*;

  localparam int FrameLen = (FrameWords < 1) ? 1 :
                            (FrameWords > WordSlots) ? WordSlots : FrameWords;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;

  typedef logic [WordSlots-1:0][WordW-1:0] frame_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [ByteW-1:0] cfg_data_i = '0;
  logic             rx_valid_i = 1'b0;
  logic             rx_ready_o;
  logic [ByteW-1:0] rx_byte_i = '0;
  logic             frame_valid_o;
  logic             frame_ready_i = 1'b0;
  logic [WordW-1:0] word0_o, word1_o, word2_o, word3_o;
  logic [WordW-1:0] word4_o, word5_o, word6_o, word7_o;

  // Bytes waiting to be sent and frames waiting to be delivered.
  logic [ByteW-1:0] byte_fifo[$];
  frame_t           frame_q[$];
  int unsigned      bytes_pushed = 0;
  int unsigned      bytes_taken = 0;
  int unsigned      frames_seen = 0;
  int unsigned      fail_cnt = 0;
  int unsigned      cycle_cnt = 0;

  // Local copy of the deframer state and its sync byte register.
  phase_e           rx_phase = PhHunt1;
  int unsigned      words_done = 0;
  logic [WordW-1:0] word_buf[WordSlots];
  logic [ByteW-1:0] sync_val = SyncReset;

  // Frame side hold-off bookkeeping.
  int unsigned      hold_left = 0;
  bit               hold_done = 1'b0;
  frame_t           got_frame;
  frame_t           want_frame;
  int               k;

  sync_word_frame_deframer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .frame_valid_o(frame_valid_o),
    .frame_ready_i(frame_ready_i),
    .word0_o      (word0_o),
    .word1_o      (word1_o),
    .word2_o      (word2_o),
    .word3_o      (word3_o),
    .word4_o      (word4_o),
    .word5_o      (word5_o),
    .word6_o      (word6_o),
    .word7_o      (word7_o)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the frame hunt by one byte and queue the frame it completes.
  task automatic deframe_byte(input logic [ByteW-1:0] b);
    logic        is_sync;
    int unsigned slot;
    frame_t      res;
    is_sync = (b == sync_val);
    case (rx_phase)
      PhHunt1: begin
        if (is_sync) rx_phase = PhHunt2;
      end
      PhHunt2: begin
        rx_phase = is_sync ? PhFirstHi : PhHunt1;
      end
      PhFirstHi: begin
        words_done = 0;
        if (!is_sync) begin
          word_buf[0] = {b, 8'h00};
          rx_phase = PhLo;
        end
      end
      PhLo: begin
        slot = words_done % WordSlots;
        word_buf[slot] = word_buf[slot] | WordW'(b);
        words_done = (words_done + 1) & 15;
        if (words_done >= FrameLen) begin
          for (int i = 0; i < WordSlots; i++) begin
            res[i] = (i < FrameLen) ? word_buf[i] : '0;
          end
          frame_q.push_back(res);
          rx_phase = PhHunt1;
        end else begin
          rx_phase = PhHi;
        end
      end
      PhHi: begin
        if (is_sync) begin
          rx_phase = PhHunt2;
        end else begin
          word_buf[words_done % WordSlots] = {b, 8'h00};
          rx_phase = PhLo;
        end
      end
      default: begin
        rx_phase = PhHunt1;
      end
    endcase
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b);
    byte_fifo.push_back(b);
    bytes_pushed++;
  endtask

  function automatic logic [ByteW-1:0] non_sync_byte();
    logic [ByteW-1:0] x;
    do begin
      x = ByteW'($urandom_range(0, 255));
    end while (x == sync_val);
    return x;
  endfunction

  // Mostly well formed frames with random content, plus aborted frames,
  // broken sync pairs and loose noise.
  task automatic gen_traffic(input int unsigned n);
    int unsigned start;
    int unsigned r;
    bit          aborted;
    start = bytes_pushed;
    while (bytes_pushed - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        repeat ($urandom_range(2, 4)) push_byte(sync_val);
        aborted = 1'b0;
        for (int w = 0; w < FrameLen && !aborted; w++) begin
          if (w > 0 && $urandom_range(0, 39) == 0) begin
            push_byte(sync_val);
            aborted = 1'b1;
          end else begin
            push_byte(non_sync_byte());
            if ($urandom_range(0, 7) == 0) push_byte(sync_val);
            else push_byte(ByteW'($urandom_range(0, 255)));
          end
        end
      end else if (r < 85) begin
        push_byte(sync_val);
        push_byte(non_sync_byte());
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait until every byte has been taken and every frame delivered.
  task automatic wait_idle();
    while (bytes_taken != bytes_pushed || frame_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [ByteW-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    sync_val = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Byte driver: presents the next queued byte once the current transaction
  // is accepted, idling at random outside the calm window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
      rx_byte_i  <= '0;
    end else begin
      if (rx_valid_i && rx_ready_o) begin
        deframe_byte(rx_byte_i);
        bytes_taken++;
      end
      if (!rx_valid_i || rx_ready_o) begin
        if (byte_fifo.size() != 0 &&
            ((bytes_taken >= 300 && bytes_taken < 500) || $urandom_range(0, 99) >= 28)) begin
          rx_valid_i <= 1'b1;
          rx_byte_i  <= byte_fifo.pop_front();
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  // Frame monitor: checks each delivered frame and drives the ready side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ready_i <= 1'b0;
    end else begin
      if (frame_valid_o && frame_ready_i) begin
        frames_seen++;
        got_frame = {word7_o, word6_o, word5_o, word4_o,
                     word3_o, word2_o, word1_o, word0_o};
        if (frame_q.size() == 0) begin
          $error("unexpected frame transaction: word0 %h", word0_o);
          fail_cnt++;
        end else begin
          want_frame = frame_q.pop_front();
          for (k = 0; k < WordSlots; k++) begin
            if (got_frame[k] !== want_frame[k]) begin
              $error("word%0d mismatch: expected %h, actual %h",
                     k, want_frame[k], got_frame[k]);
              fail_cnt++;
            end
          end
        end
      end
      // One long hold-off lets the byte side back up against a waiting frame.
      if (hold_left != 0) begin
        hold_left--;
        frame_ready_i <= 1'b0;
      end else if (!hold_done && frames_seen == 8) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        frame_ready_i <= 1'b0;
      end else if (frames_seen >= 20 && frames_seen < 30) begin
        frame_ready_i <= 1'b1;
      end else begin
        frame_ready_i <= ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Reset, directed frame, then random phases under several sync values.
  initial begin
    logic [ByteW-1:0] directed[25];
    logic [ByteW-1:0] sync_plan[4];
    for (int i = 0; i < WordSlots; i++) word_buf[i] = '0;
    // Repeated sync, a low byte equal to sync, an aborted frame, then a full
    // frame with extreme values.
    directed = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFE, 8'h00, 8'hFF,
                 8'hFF, 8'h00, 8'h00, 8'hFE, 8'hFF, 8'h80, 8'h7F, 8'h7F,
                 8'h80, 8'h01, 8'hFE, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h12,
                 8'hFF};
    sync_plan = '{8'h00, ByteW'($urandom_range(1, 254)),
                  ByteW'($urandom_range(1, 254)), 8'hFF};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) push_byte(directed[i]);
    gen_traffic(225);
    wait_idle();
    foreach (sync_plan[p]) begin
      write_sync(sync_plan[p]);
      gen_traffic(250);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/swfd_pkg.sv
sv/swfd_ctrl.sv
sv/sync_word_frame_deframer.sv
tb/sync_word_frame_deframer_tb.sv
